>>> src/humidity_sensor_frame_converter_unit_macros.svh
// Assertion macros for the humidity sensor frame converter
`ifndef HUMIDITY_SENSOR_FRAME_CONVERTER_UNIT_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define HSFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hsfc_pkg.sv
// Shared types and constants of the humidity sensor frame converter
package hsfc_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_NO_TEMP = 2'd2
  } status_t;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  localparam logic [7:0]  CRC_POLY     = 8'h31;
  localparam logic [7:0]  CRC_MSB_MASK = 8'h80;
  localparam logic [7:0]  STATUS_MASK  = 8'hFC;

  localparam logic [14:0] TEMP_SCALE   = 15'd17572;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
  localparam logic [13:0] HUM_SCALE    = 14'd12500;
  localparam logic signed [16:0] HUM_OFFSET  = 17'sd600;
  localparam logic signed [15:0] TEMP_REF    = 16'sd2500;
  localparam logic signed [31:0] HUM_TCOMP   = 32'sd9830;
  localparam logic signed [16:0] HUM_MAX     = 17'sd10000;
  localparam logic signed [14:0] TEMP_RESET  = 15'sd2500;

  typedef struct packed {
    status_t            status;
    logic               kind;
    logic signed [14:0] value;
    logic [15:0]        raw_code;
  } result_t;

  typedef struct packed {
    logic               load;
    logic               valid;
    logic signed [14:0] temp;
  } temp_upd_t;

endpackage

>>> src/hsfc_crc8.sv
// CRC-8 (polynomial 0x31, zero init) over the two data bytes
module hsfc_crc8
  import hsfc_pkg::*;
(
  input  logic [7:0] msb_i,
  input  logic [7:0] lsb_i,
  output logic [7:0] crc_o
);

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB_MASK) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign crc_o = crc_byte(crc_byte(8'h00, msb_i), lsb_i);

endmodule

>>> src/hsfc_convert.sv
// Code conversion to hundredths, humidity compensation and status selection
module hsfc_convert
  import hsfc_pkg::*;
(
  input  logic               kind_i,
  input  logic [7:0]         msb_i,
  input  logic [7:0]         lsb_i,
  input  logic               crc_ok_i,
  input  logic signed [14:0] temp_i,
  input  logic               temp_valid_i,
  output result_t            res_o,
  output temp_upd_t          upd_o
);

  logic [15:0]        code;
  logic [30:0]        t_prod;
  logic signed [15:0] t_val;
  logic [29:0]        h_prod;
  logic signed [15:0] t_diff;
  logic signed [31:0] c_prod;
  logic signed [16:0] h_sum;
  logic signed [14:0] h_val;

  assign code   = {msb_i, lsb_i & STATUS_MASK};
  assign t_prod = 31'(TEMP_SCALE) * 31'(code);
  assign t_val  = $signed({1'b0, t_prod[30:16]}) - TEMP_OFFSET;
  assign h_prod = 30'(HUM_SCALE) * 30'(code);
  assign t_diff = 16'(temp_i) - TEMP_REF;
  assign c_prod = 32'(t_diff) * HUM_TCOMP;
  assign h_sum  = $signed({3'b000, h_prod[29:16]}) - HUM_OFFSET
                + 17'($signed(c_prod[31:16]));

  always_comb begin
    if (h_sum < 17'sd0) begin
      h_val = 15'sd0;
    end else if (h_sum > HUM_MAX) begin
      h_val = HUM_MAX[14:0];
    end else begin
      h_val = h_sum[14:0];
    end
  end

  always_comb begin
    res_o.kind     = kind_i;
    res_o.raw_code = code;
    res_o.status   = ST_OK;
    res_o.value    = 15'sd0;
    upd_o.load     = 1'b0;
    upd_o.valid    = 1'b0;
    upd_o.temp     = t_val[14:0];
    if (!crc_ok_i) begin
      res_o.status = ST_CRC_ERR;
      upd_o.load   = (kind_i == KIND_TEMP);
    end else if (kind_i == KIND_TEMP) begin
      res_o.value = t_val[14:0];
      upd_o.load  = 1'b1;
      upd_o.valid = 1'b1;
    end else if (!temp_valid_i) begin
      res_o.status = ST_NO_TEMP;
    end else begin
      res_o.value = h_val;
    end
  end

endmodule

>>> src/humidity_sensor_frame_converter_unit.sv
// Top level of the humidity sensor frame converter
// Takes one sensor reply per transaction and returns one converted result per reply.
// A reply is registered, checked and converted in the next cycle, and the result waits in
// an output register, so one reply can be taken every cycle while the result side keeps up.
// The stored temperature used for humidity compensation is the one from the latest
// temperature reply ahead of it; a temperature reply with a bad CRC clears it until the
// next good one. Reset needs no clearing pass.
`include "humidity_sensor_frame_converter_unit_macros.svh"

module humidity_sensor_frame_converter_unit
  import hsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // msb_byte[7:0], lsb_byte[15:8], check_byte[23:16]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], value[16:2], raw_code[32:17], zero[39:33]
  output logic        out_tuser   // kind_out[0]
);

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_kind_r;
  logic [7:0]         s1_msb_r, s1_lsb_r, s1_chk_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;
  logic signed [14:0] temp_r;
  logic               temp_valid_r;

  logic               s2_ready;
  logic               s1_adv;
  logic               in_acc;
  logic [7:0]         crc;
  result_t            res;
  temp_upd_t          upd;

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_adv    = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  hsfc_crc8 u_crc (
    .msb_i (s1_msb_r),
    .lsb_i (s1_lsb_r),
    .crc_o (crc)
  );

  hsfc_convert u_conv (
    .kind_i       (s1_kind_r),
    .msb_i        (s1_msb_r),
    .lsb_i        (s1_lsb_r),
    .crc_ok_i     (crc == s1_chk_r),
    .temp_i       (temp_r),
    .temp_valid_i (temp_valid_r),
    .res_o        (res),
    .upd_o        (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      temp_r       <= TEMP_RESET;
      temp_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv && upd.load) begin
        temp_valid_r <= upd.valid;
        if (upd.valid) begin
          temp_r <= upd.temp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_msb_r  <= in_tdata[7:0];
      s1_lsb_r  <= in_tdata[15:8];
      s1_chk_r  <= in_tdata[23:16];
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.raw_code, out_res_r.value, out_res_r.status};

  `HSFC_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid_r && out_res_r.status != ST_OK,
    out_res_r.value == 15'sd0, "nonzero value on an error result")

  `HSFC_ASSERT_NOW(a_hum_range, clk, rst_n, out_valid_r && out_res_r.kind == KIND_HUM,
    out_res_r.value >= 15'sd0 && out_res_r.value <= HUM_MAX[14:0], "humidity out of range")

  `HSFC_ASSERT_NOW(a_code_mask, clk, rst_n, out_valid_r, out_res_r.raw_code[1:0] == 2'b00,
    "status bits not cleared in raw code")

  `HSFC_ASSERT_NEXT(a_temp_load, clk, rst_n,
    s1_adv && s1_kind_r == KIND_TEMP && crc == s1_chk_r,
    temp_valid_r && temp_r == out_res_r.value, "stored temperature not updated")

endmodule

>>> tb/tb_top.sv
// Testbench for the humidity sensor frame converter: directed table, then random replies
module tb_top;
  import hsfc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_REPS = 1000;

  typedef enum logic [1:0] {
    CRC_GIVEN,
    CRC_GOOD,
    CRC_FLIP
  } crc_pick_t;

  typedef struct {
    logic               kind;
    logic [7:0]         msb;
    logic [7:0]         lsb;
    logic [7:0]         chk;
    crc_pick_t          crc;
    bit                 typed;
    status_t            status;
    logic signed [14:0] value;
    logic [15:0]        raw_code;
  } reply_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  result_t     pending_results[$];
  reply_row_t  reply_plan[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          ready_cycle = 0;
  int          ready_mode = 0;

  int          held_temp;
  bit          held_temp_ok;

  humidity_sensor_frame_converter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] crc8_of(logic [7:0] msb, logic [7:0] lsb);
    logic [7:0] crc;
    logic [7:0] bytes [2];
    bytes[0] = msb;
    bytes[1] = lsb;
    crc = 8'h00;
    for (int i = 0; i < 2; i++) begin
      crc = crc ^ bytes[i];
      for (int k = 0; k < 8; k++) begin
        if (crc[7]) crc = {crc[6:0], 1'b0} ^ 8'h31;
        else        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // update the held temperature and return the converted reply
  function automatic result_t convert_reply(logic kind, logic [7:0] msb, logic [7:0] lsb,
                                            logic [7:0] chk);
    result_t     r;
    logic [15:0] code;
    int          v;
    int unsigned prod;
    code = {msb, lsb & 8'hFC};
    v = 0;
    r.status = ST_OK;
    if (crc8_of(msb, lsb) != chk) begin
      r.status = ST_CRC_ERR;
      if (kind == KIND_TEMP) held_temp_ok = 1'b0;
    end else if (kind == KIND_TEMP) begin
      prod = 32'd17572 * code;
      v = -4685 + int'(prod >> 16);
      held_temp = v;
      held_temp_ok = 1'b1;
    end else if (!held_temp_ok) begin
      r.status = ST_NO_TEMP;
    end else begin
      prod = 32'd12500 * code;
      v = -600 + int'(prod >> 16) + (((held_temp - 2500) * 9830) >>> 16);
      if (v < 0) v = 0;
      if (v > 10000) v = 10000;
    end
    r.kind = kind;
    r.value = v[14:0];
    r.raw_code = code;
    return r;
  endfunction

  function automatic reply_row_t plan_row(logic kind, logic [7:0] msb, logic [7:0] lsb,
                                          logic [7:0] chk, crc_pick_t crc, bit typed,
                                          status_t status, logic signed [14:0] value,
                                          logic [15:0] raw_code);
    reply_row_t row;
    row.kind = kind;
    row.msb = msb;
    row.lsb = lsb;
    row.chk = chk;
    row.crc = crc;
    row.typed = typed;
    row.status = status;
    row.value = value;
    row.raw_code = raw_code;
    return row;
  endfunction

  task automatic report_error(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_reply(logic kind, logic [7:0] msb, logic [7:0] lsb, logic [7:0] chk,
                            bit typed, result_t typed_res);
    result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {chk, lsb, msb};
    do @(posedge clk); while (!in_tready);
    predicted = convert_reply(kind, msb, lsb, chk);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_cycle % 64 == 0) ready_mode <= $urandom_range(0, 3);
    ready_cycle <= ready_cycle + 1;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (ready_cycle % 4 == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = status_t'(out_tdata[1:0]);
      got.kind     = out_tuser;
      got.value    = out_tdata[16:2];
      got.raw_code = out_tdata[32:17];
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d kind %0d value %0d raw %h",
                               got.status, got.kind, got.value, got.raw_code));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.kind !== want.kind ||
            got.value !== want.value || got.raw_code !== want.raw_code) begin
          report_error($sformatf(
            "mismatch: exp st %0d k %0d v %0d raw %h, got st %0d k %0d v %0d raw %h",
            want.status, want.kind, want.value, want.raw_code,
            got.status, got.kind, got.value, got.raw_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    result_t    typed_res;
    reply_row_t row;
    logic       kind;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] chk;
    logic [7:0] good;

    held_temp = 2500;
    held_temp_ok = 1'b0;

    reply_plan.push_back(plan_row(KIND_HUM,  8'h80, 8'h00, 8'h00, CRC_GOOD,  1, ST_NO_TEMP,
                                  15'sd0, 16'h8000));
    reply_plan.push_back(plan_row(KIND_HUM,  8'hFF, 8'hFF, 8'h00, CRC_FLIP,  1, ST_CRC_ERR,
                                  15'sd0, 16'hFFFC));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'h00, 8'h00, 8'h00, CRC_GIVEN, 1, ST_OK,
                                  -15'sd4685, 16'h0000));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h00, 8'h00, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'hFF, 8'hFF, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h00, 8'h00, 8'h00, CRC_FLIP,  1, ST_CRC_ERR,
                                  15'sd0, 16'h0000));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'hFF, 8'hFF, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h00, 8'h00, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'hFF, 8'hFF, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'hFF, 8'hFE, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'h66, 8'h4E, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h4E, 8'h85, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h7C, 8'h83, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'h66, 8'h4E, 8'h00, CRC_FLIP,  1, ST_CRC_ERR,
                                  15'sd0, 16'h664C));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h68, 8'h3A, 8'h00, CRC_GOOD,  1, ST_NO_TEMP,
                                  15'sd0, 16'h6838));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h68, 8'h3A, 8'h00, CRC_FLIP,  1, ST_CRC_ERR,
                                  15'sd0, 16'h6838));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'h68, 8'h3A, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h00, 8'h03, 8'h00, CRC_GOOD,  0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'hFF, 8'hFC, 8'hFF, CRC_GIVEN, 0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_TEMP, 8'h80, 8'h00, 8'hFF, CRC_GIVEN, 0, ST_OK, 0, 0));
    reply_plan.push_back(plan_row(KIND_HUM,  8'h80, 8'h00, 8'h00, CRC_GOOD,  1, ST_NO_TEMP,
                                  15'sd0, 16'h8000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (reply_plan[i]) begin
      row = reply_plan[i];
      good = crc8_of(row.msb, row.lsb);
      case (row.crc)
        CRC_GOOD: chk = good;
        CRC_FLIP: chk = good ^ 8'h01;
        default:  chk = row.chk;
      endcase
      typed_res.status   = row.status;
      typed_res.kind     = row.kind;
      typed_res.value    = row.value;
      typed_res.raw_code = row.raw_code;
      pace_sender();
      send_reply(row.kind, row.msb, row.lsb, chk, row.typed, typed_res);
    end

    drain_results();

    typed_res = '0;
    for (int n = 0; n < RANDOM_REPS; n++) begin
      kind = ($urandom_range(0, 2) == 0) ? KIND_TEMP : KIND_HUM;
      case ($urandom_range(0, 7))
        0: msb = 8'h00;
        1: msb = 8'hFF;
        default: msb = 8'($urandom_range(0, 255));
      endcase
      lsb = 8'($urandom_range(0, 255));
      good = crc8_of(msb, lsb);
      case ($urandom_range(0, 9))
        0: chk = 8'($urandom_range(0, 255));
        1: chk = good ^ (8'h01 << $urandom_range(0, 7));
        default: chk = good;
      endcase
      if (n == RANDOM_REPS / 2) drain_results();
      pace_sender();
      send_reply(kind, msb, lsb, chk, 0, typed_res);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
